[rtl/core/dms_pkg.sv]
`default_nettype none

package dms_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int FUNC_W      = 2;
  localparam int TYPE_W      = 4;
  localparam int ENV_W       = 16;
  localparam int LINE_W      = 16;
  localparam int COL_W       = 12;
  localparam int MASK_W      = 11;
  localparam int KIND_W      = 3;
  localparam int DEPTH_OUT_W = 6;

  localparam logic [MASK_W-1:0] MASK_RESET     = 11'd1584;
  localparam logic [TYPE_W-1:0] TYPE_BEGIN_END = 4'd5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_OPEN   = 2'd0,
    FUNC_CLOSE  = 2'd1,
    FUNC_REPORT = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSHED       = 3'd0,
    KIND_FULL         = 3'd1,
    KIND_CLOSED       = 3'd2,
    KIND_CLOSE_EMPTY  = 3'd3,
    KIND_ENV_MISMATCH = 3'd4,
    KIND_MISMATCH     = 3'd5,
    KIND_UNCLOSED     = 3'd6,
    KIND_NONE_OPEN    = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    SRC_CUR  = 2'd0,
    SRC_RD   = 2'd1,
    SRC_TOP  = 2'd2,
    SRC_ZERO = 2'd3
  } src_t;

  typedef enum logic [0:0] {
    ADDR_TOP  = 1'b0,
    ADDR_NEXT = 1'b1
  } addr_sel_t;

  typedef enum logic [1:0] {
    DEP_CNT   = 2'd0,
    DEP_INC   = 2'd1,
    DEP_DEC   = 2'd2,
    DEP_FOUND = 2'd3
  } dep_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD  = 2'd0,
    CNT_INC   = 2'd1,
    CNT_DEC   = 2'd2,
    CNT_FOUND = 2'd3
  } cnt_op_t;

  typedef struct packed {
    logic [TYPE_W-1:0] dtype;
    logic              has_env;
    logic [ENV_W-1:0]  env_id;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
  } entry_t;

  typedef struct packed {
    logic      cap_in;
    logic      push;
    logic      rd_en;
    addr_sel_t rd_sel;
    logic      found_load;
    logic      found_clr;
    logic      top_load;
    cnt_op_t   cnt_op;
    logic      out_load;
    kind_t     out_kind;
    src_t      out_src;
    dep_sel_t  out_dep;
    logic      out_last;
  } cmd_t;

  typedef struct packed {
    logic is_report;
    logic cnt_zero;
    logic cnt_one;
    logic full;
    logic type_eq;
    logic be_env_bad;
    logic rd_match;
    logic structural;
    logic ptr_zero;
    logic ptr_at_found;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[rtl/core/dms_ctrl.sv]
`default_nettype none

module dms_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic [dms_pkg::FUNC_W-1:0]   in_func,
  output logic                              in_stall,
  input  wire dms_pkg::stat_t               stat,
  output dms_pkg::cmd_t                     cmd
);
  import dms_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PUSH   = 7'b0000010,
    S_SINGLE = 7'b0000100,
    S_TOP    = 7'b0001000,
    S_SEARCH = 7'b0010000,
    S_MISS   = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.rd_sel     = ADDR_TOP;
    cmd.cnt_op     = CNT_HOLD;
    cmd.out_kind   = KIND_PUSHED;
    cmd.out_src    = SRC_CUR;
    cmd.out_dep    = DEP_CNT;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.cap_in = 1'b1;
          case (in_func)
            FUNC_OPEN: begin
              state_nxt = S_PUSH;
            end
            FUNC_CLOSE: begin
              if (stat.cnt_zero) begin
                state_nxt = S_SINGLE;
              end else begin
                cmd.rd_en = 1'b1;
                state_nxt = S_TOP;
              end
            end
            FUNC_REPORT: begin
              if (stat.cnt_zero) begin
                state_nxt = S_SINGLE;
              end else begin
                cmd.rd_en     = 1'b1;
                cmd.found_clr = 1'b1;
                state_nxt     = S_EMIT;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_PUSH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          cmd.out_src  = SRC_CUR;
          if (stat.full) begin
            cmd.out_kind = KIND_FULL;
            cmd.out_dep  = DEP_CNT;
          end else begin
            cmd.push     = 1'b1;
            cmd.cnt_op   = CNT_INC;
            cmd.out_kind = KIND_PUSHED;
            cmd.out_dep  = DEP_INC;
          end
          state_nxt = S_IDLE;
        end
      end
      S_SINGLE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          cmd.out_dep  = DEP_CNT;
          if (stat.is_report) begin
            cmd.out_kind = KIND_NONE_OPEN;
            cmd.out_src  = SRC_ZERO;
          end else begin
            cmd.out_kind = KIND_CLOSE_EMPTY;
            cmd.out_src  = SRC_CUR;
          end
          state_nxt = S_IDLE;
        end
      end
      S_TOP: begin
        cmd.top_load = 1'b1;
        if (stat.type_eq) begin
          if (stat.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_last = 1'b1;
            cmd.out_src  = SRC_RD;
            if (stat.be_env_bad) begin
              cmd.out_kind = KIND_ENV_MISMATCH;
              cmd.out_dep  = DEP_CNT;
            end else begin
              cmd.out_kind = KIND_CLOSED;
              cmd.out_dep  = DEP_DEC;
              cmd.cnt_op   = CNT_DEC;
            end
            state_nxt = S_IDLE;
          end
        end else if (stat.structural && !stat.cnt_one) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ADDR_NEXT;
          state_nxt  = S_SEARCH;
        end else begin
          state_nxt = S_MISS;
        end
      end
      S_SEARCH: begin
        if (stat.rd_match) begin
          cmd.found_load = 1'b1;
          cmd.rd_en      = 1'b1;
          cmd.rd_sel     = ADDR_TOP;
          state_nxt      = S_EMIT;
        end else if (stat.ptr_zero) begin
          state_nxt = S_MISS;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ADDR_NEXT;
        end
      end
      S_MISS: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          cmd.out_kind = KIND_MISMATCH;
          cmd.out_src  = SRC_TOP;
          cmd.out_dep  = DEP_CNT;
          state_nxt    = S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_RD;
          cmd.out_dep  = stat.is_report ? DEP_CNT : DEP_FOUND;
          cmd.out_last = stat.ptr_at_found;
          if (stat.ptr_at_found) begin
            cmd.out_kind = stat.is_report ? KIND_UNCLOSED : KIND_CLOSED;
            cmd.cnt_op   = stat.is_report ? CNT_HOLD : CNT_FOUND;
            state_nxt    = S_IDLE;
          end else begin
            cmd.out_kind = KIND_UNCLOSED;
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = ADDR_NEXT;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/dms_datapath.sv]
`default_nettype none

module dms_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [dms_pkg::FUNC_W-1:0]        in_func,
  input  wire logic [dms_pkg::TYPE_W-1:0]        in_delim_type,
  input  wire logic                              in_has_env,
  input  wire logic [dms_pkg::ENV_W-1:0]         in_env_id,
  input  wire logic [dms_pkg::LINE_W-1:0]        in_src_line,
  input  wire logic [dms_pkg::COL_W-1:0]         in_src_col,
  input  wire logic                              cfg_we,
  input  wire logic [dms_pkg::MASK_W-1:0]        cfg_wdata,
  input  wire logic                              out_stall,
  output logic                                   out_valid,
  output logic [dms_pkg::KIND_W-1:0]             out_result_kind,
  output logic [dms_pkg::TYPE_W-1:0]             out_entry_type,
  output logic                                   out_entry_has_env,
  output logic [dms_pkg::ENV_W-1:0]              out_entry_env_id,
  output logic [dms_pkg::LINE_W-1:0]             out_entry_line,
  output logic [dms_pkg::COL_W-1:0]              out_entry_col,
  output logic [dms_pkg::DEPTH_OUT_W-1:0]        out_depth_after,
  output logic                                   out_last_result,
  input  wire dms_pkg::cmd_t                     cmd,
  output dms_pkg::stat_t                         stat
);
  import dms_pkg::*;

  entry_t              mem [STACK_DEPTH];
  entry_t              rd_data_r;
  entry_t              top_r;
  entry_t              cur_r;
  entry_t              out_entry_r;
  entry_t              out_entry_nxt;
  func_t               func_r;
  logic [MASK_W-1:0]   mask_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]   ptr_r;
  logic [ADDR_W-1:0]   found_r;
  logic [ADDR_W-1:0]   rd_addr;
  logic [CNT_W-1:0]    cnt_m1;
  logic [CNT_W-1:0]    cnt_p1;
  logic [CNT_W-1:0]    dep_val;
  logic [15:0]         mask_ext;
  logic                env_ok;
  logic                out_valid_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic [DEPTH_OUT_W-1:0] out_depth_r;
  logic                out_last_r;

  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign cnt_p1   = cnt_r + CNT_W'(1);
  assign mask_ext = 16'(mask_r);
  assign rd_addr  = (cmd.rd_sel == ADDR_NEXT) ? (ptr_r - ADDR_W'(1)) : cnt_m1[ADDR_W-1:0];

  assign env_ok = (rd_data_r.has_env == cur_r.has_env) &&
                  (!cur_r.has_env || (rd_data_r.env_id == cur_r.env_id));

  always_comb begin
    stat              = '0;
    stat.is_report    = (func_r == FUNC_REPORT);
    stat.cnt_zero     = (cnt_r == '0);
    stat.cnt_one      = (cnt_r == CNT_W'(1));
    stat.full         = (cnt_r == CNT_W'(STACK_DEPTH));
    stat.type_eq      = (rd_data_r.dtype == cur_r.dtype);
    stat.be_env_bad   = (cur_r.dtype == TYPE_BEGIN_END) && !env_ok;
    stat.rd_match     = stat.type_eq && !stat.be_env_bad;
    stat.structural   = mask_ext[cur_r.dtype];
    stat.ptr_zero     = (ptr_r == '0);
    stat.ptr_at_found = (ptr_r == found_r);
    stat.out_free     = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RESET;
    end else if (cfg_we) begin
      mask_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      func_r        <= func_t'(in_func);
      cur_r.dtype   <= in_delim_type;
      cur_r.has_env <= in_has_env;
      cur_r.env_id  <= in_env_id;
      cur_r.line    <= in_src_line;
      cur_r.col     <= in_src_col;
    end
    if (cmd.top_load) begin
      top_r <= rd_data_r;
    end
    if (cmd.found_load) begin
      found_r <= ptr_r;
    end else if (cmd.found_clr) begin
      found_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[cnt_r[ADDR_W-1:0]] <= cur_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
      ptr_r     <= rd_addr;
    end
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC:   cnt_nxt = cnt_p1;
      CNT_DEC:   cnt_nxt = cnt_m1;
      CNT_FOUND: cnt_nxt = CNT_W'(found_r);
      default:   cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    case (cmd.out_src)
      SRC_CUR: out_entry_nxt = cur_r;
      SRC_RD:  out_entry_nxt = rd_data_r;
      SRC_TOP: out_entry_nxt = top_r;
      default: out_entry_nxt = '0;
    endcase
    case (cmd.out_dep)
      DEP_INC:   dep_val = cnt_p1;
      DEP_DEC:   dep_val = cnt_m1;
      DEP_FOUND: dep_val = CNT_W'(found_r);
      default:   dep_val = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_entry_r <= out_entry_nxt;
      out_kind_r  <= cmd.out_kind;
      out_depth_r <= DEPTH_OUT_W'(dep_val);
      out_last_r  <= cmd.out_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_entry_type    = out_entry_r.dtype;
  assign out_entry_has_env = out_entry_r.has_env;
  assign out_entry_env_id  = out_entry_r.env_id;
  assign out_entry_line    = out_entry_r.line;
  assign out_entry_col     = out_entry_r.col;
  assign out_depth_after   = out_depth_r;
  assign out_last_result   = out_last_r;

endmodule

`default_nettype wire

[rtl/core/delimiter_match_stack.sv]
// Channel   Direction  Handshake              Transaction
// in_*      input      in_valid / in_stall    one delimiter token or report request
// out_*     output     out_valid / out_stall  one result; out_last_result ends a token
// cfg_*     input      cfg_we                 structural_mask write
//
// Open, a close that matches the top and the other single-result cases capture the token and then
// emit one result; a mismatch without a search checks the top first, and the ignored function code emits none.
// Structural search reads the stack one entry per cycle below the top, then emits one result
// per cycle while out_stall is low; when no entry matches it ends in a mismatch result.
// Report emits one result per open entry. rst_n clears the depth count, the control state and
// the mask to 1584; the stack memory is not cleared. out_stall holds each emitting step.
`default_nettype none

module delimiter_match_stack (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [dms_pkg::FUNC_W-1:0]        in_func,
  input  wire logic [dms_pkg::TYPE_W-1:0]        in_delim_type,
  input  wire logic                              in_has_env,
  input  wire logic [dms_pkg::ENV_W-1:0]         in_env_id,
  input  wire logic [dms_pkg::LINE_W-1:0]        in_src_line,
  input  wire logic [dms_pkg::COL_W-1:0]         in_src_col,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [dms_pkg::KIND_W-1:0]             out_result_kind,
  output logic [dms_pkg::TYPE_W-1:0]             out_entry_type,
  output logic                                   out_entry_has_env,
  output logic [dms_pkg::ENV_W-1:0]              out_entry_env_id,
  output logic [dms_pkg::LINE_W-1:0]             out_entry_line,
  output logic [dms_pkg::COL_W-1:0]              out_entry_col,
  output logic [dms_pkg::DEPTH_OUT_W-1:0]        out_depth_after,
  output logic                                   out_last_result,
  input  wire logic                              cfg_we,
  input  wire logic [dms_pkg::MASK_W-1:0]        cfg_wdata
);
  import dms_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  dms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  dms_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_func           (in_func),
    .in_delim_type     (in_delim_type),
    .in_has_env        (in_has_env),
    .in_env_id         (in_env_id),
    .in_src_line       (in_src_line),
    .in_src_col        (in_src_col),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_result_kind   (out_result_kind),
    .out_entry_type    (out_entry_type),
    .out_entry_has_env (out_entry_has_env),
    .out_entry_env_id  (out_entry_env_id),
    .out_entry_line    (out_entry_line),
    .out_entry_col     (out_entry_col),
    .out_depth_after   (out_depth_after),
    .out_last_result   (out_last_result),
    .cmd               (cmd),
    .stat              (stat)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_func != FUNC_NOP)) |=> in_stall)
    else $error("input taken again right after a transaction");

  a_only_unclosed_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_result) |-> (out_result_kind == KIND_UNCLOSED))
    else $error("non-final result that is not an unclosed entry");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_depth_after <= DEPTH_OUT_W'(STACK_DEPTH)))
    else $error("depth beyond stack size");

  a_push_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == KIND_PUSHED)) |-> (out_depth_after != '0))
    else $error("push reported with empty stack");

endmodule

`default_nettype wire

[tb/delimiter_match_stack_tb.sv]
`timescale 1ns / 1ps

module delimiter_match_stack_tb;
  import dms_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 8;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int PHASES         = 4;
  localparam int TOKENS_PER_PH  = 84;
  localparam int REPORT_LIMIT   = 10;
  localparam int DIRECTED_ROWS  = 24;

  localparam logic [TYPE_W-1:0] T_BRACE     = 4'd0;
  localparam logic [TYPE_W-1:0] T_BRACKET   = 4'd1;
  localparam logic [TYPE_W-1:0] T_PAREN     = 4'd2;
  localparam logic [TYPE_W-1:0] T_DDOLLAR   = 4'd4;
  localparam logic [TYPE_W-1:0] T_ANGLE     = 4'd8;
  localparam logic [TYPE_W-1:0] T_LABEL     = 4'd9;
  localparam logic [TYPE_W-1:0] T_BLOCK     = 4'd10;
  localparam logic [TYPE_W-1:0] T_UNKNOWN   = 4'd15;

  typedef struct {
    func_t             func;
    logic [TYPE_W-1:0] dtype;
    logic              has_env;
    logic [ENV_W-1:0]  env_id;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
  } token_t;

  typedef struct {
    logic [TYPE_W-1:0] dtype;
    logic              has_env;
    logic [ENV_W-1:0]  env_id;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
  } open_rec_t;

  typedef struct {
    logic [KIND_W-1:0]      kind;
    open_rec_t              rec;
    logic [DEPTH_OUT_W-1:0] depth;
    logic                   last;
  } result_t;

  typedef struct {
    token_t tok;
    bit     typed;
    kind_t  tkind;
    int     tdepth;
  } stim_row_t;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{FUNC_REPORT, T_BRACE, 1'b0, 16'h0000, 16'h0000, 12'h000}, 1, KIND_NONE_OPEN, 0},
    '{'{FUNC_CLOSE, T_BLOCK, 1'b1, 16'hFFFF, 16'hFFFF, 12'hFFF}, 1, KIND_CLOSE_EMPTY, 0},
    '{'{FUNC_NOP, T_UNKNOWN, 1'b1, 16'hFFFF, 16'hFFFF, 12'hFFF}, 0, KIND_PUSHED, 0},
    '{'{FUNC_OPEN, TYPE_BEGIN_END, 1'b1, 16'hFFFF, 16'hFFFF, 12'hFFF}, 1, KIND_PUSHED, 1},
    '{'{FUNC_OPEN, T_BRACE, 1'b0, 16'h0000, 16'h0000, 12'h000}, 1, KIND_PUSHED, 2},
    '{'{FUNC_OPEN, T_PAREN, 1'b0, 16'h00A5, 16'd12, 12'd7}, 1, KIND_PUSHED, 3},
    '{'{FUNC_OPEN, T_UNKNOWN, 1'b1, 16'h5A5A, 16'd13, 12'd1}, 1, KIND_PUSHED, 4},
    '{'{FUNC_CLOSE, T_UNKNOWN, 1'b0, 16'h0000, 16'd14, 12'd2}, 0, KIND_PUSHED, 0},
    '{'{FUNC_CLOSE, T_BRACKET, 1'b0, 16'h0000, 16'd15, 12'd3}, 0, KIND_PUSHED, 0},
    '{'{FUNC_CLOSE, TYPE_BEGIN_END, 1'b1, 16'h1234, 16'd16, 12'd4}, 0, KIND_PUSHED, 0},
    '{'{FUNC_CLOSE, TYPE_BEGIN_END, 1'b0, 16'hFFFF, 16'd17, 12'd5}, 0, KIND_PUSHED, 0},
    '{'{FUNC_REPORT, T_BRACE, 1'b0, 16'h0000, 16'd18, 12'd6}, 0, KIND_PUSHED, 0},
    '{'{FUNC_CLOSE, T_PAREN, 1'b0, 16'h0000, 16'd19, 12'd7}, 0, KIND_PUSHED, 0},
    '{'{FUNC_OPEN, TYPE_BEGIN_END, 1'b0, 16'd77, 16'd20, 12'd8}, 1, KIND_PUSHED, 3},
    '{'{FUNC_CLOSE, TYPE_BEGIN_END, 1'b1, 16'd77, 16'd21, 12'd9}, 0, KIND_PUSHED, 0},
    '{'{FUNC_CLOSE, TYPE_BEGIN_END, 1'b0, 16'd99, 16'd22, 12'd10}, 0, KIND_PUSHED, 0},
    '{'{FUNC_OPEN, T_LABEL, 1'b1, 16'd3, 16'd23, 12'd11}, 1, KIND_PUSHED, 3},
    '{'{FUNC_OPEN, T_BRACE, 1'b0, 16'd0, 16'd24, 12'd12}, 1, KIND_PUSHED, 4},
    '{'{FUNC_OPEN, T_ANGLE, 1'b1, 16'd9, 16'd25, 12'd13}, 1, KIND_PUSHED, 5},
    '{'{FUNC_CLOSE, T_LABEL, 1'b0, 16'd0, 16'd26, 12'd14}, 0, KIND_PUSHED, 0},
    '{'{FUNC_CLOSE, TYPE_BEGIN_END, 1'b1, 16'hFFFF, 16'd27, 12'd15}, 0, KIND_PUSHED, 0},
    '{'{FUNC_OPEN, T_DDOLLAR, 1'b0, 16'd0, 16'd28, 12'd16}, 1, KIND_PUSHED, 1},
    '{'{FUNC_CLOSE, T_DDOLLAR, 1'b0, 16'd0, 16'd29, 12'd17}, 0, KIND_PUSHED, 0},
    '{'{FUNC_REPORT, T_BRACE, 1'b0, 16'h0000, 16'd30, 12'd18}, 1, KIND_NONE_OPEN, 0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [FUNC_W-1:0]      in_func = '0;
  logic [TYPE_W-1:0]      in_delim_type = '0;
  logic                   in_has_env = 1'b0;
  logic [ENV_W-1:0]       in_env_id = '0;
  logic [LINE_W-1:0]      in_src_line = '0;
  logic [COL_W-1:0]       in_src_col = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [KIND_W-1:0]      out_result_kind;
  logic [TYPE_W-1:0]      out_entry_type;
  logic                   out_entry_has_env;
  logic [ENV_W-1:0]       out_entry_env_id;
  logic [LINE_W-1:0]      out_entry_line;
  logic [COL_W-1:0]       out_entry_col;
  logic [DEPTH_OUT_W-1:0] out_depth_after;
  logic                   out_last_result;
  logic                   cfg_we = 1'b0;
  logic [MASK_W-1:0]      cfg_wdata = '0;

  open_rec_t         open_stack [STACK_DEPTH];
  int                open_depth = 0;
  logic [MASK_W-1:0] struct_mask = MASK_RESET;
  result_t           pending_results [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int fill_left = 0;
  int cycle_count = 0;
  int mismatch_count = 0;
  int tokens_accepted = 0;
  int results_checked = 0;
  int peak_depth = 0;
  int full_rejects = 0;
  int skipped_entries = 0;

  delimiter_match_stack u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_delim_type     (in_delim_type),
    .in_has_env        (in_has_env),
    .in_env_id         (in_env_id),
    .in_src_line       (in_src_line),
    .in_src_col        (in_src_col),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_entry_type    (out_entry_type),
    .out_entry_has_env (out_entry_has_env),
    .out_entry_env_id  (out_entry_env_id),
    .out_entry_line    (out_entry_line),
    .out_entry_col     (out_entry_col),
    .out_depth_after   (out_depth_after),
    .out_last_result   (out_last_result),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic bit env_agrees(open_rec_t a, open_rec_t b);
    if (a.has_env != b.has_env) return 0;
    return (a.has_env == 1'b0) || (a.env_id == b.env_id);
  endfunction

  function automatic bit rec_matches(open_rec_t e, open_rec_t c);
    if (e.dtype != c.dtype) return 0;
    if (c.dtype == TYPE_BEGIN_END) return env_agrees(e, c);
    return 1;
  endfunction

  // Update the shadow stack for one accepted token and queue the results it yields.
  task automatic predict_matches(input token_t t, input bit typed, input result_t typed_res);
    open_rec_t     cur;
    open_rec_t     top;
    open_rec_t     refs [$];
    logic [KIND_W-1:0] kinds [$];
    result_t       r;
    int            found;
    int            i;
    cur = '{t.dtype, t.has_env, t.env_id, t.line, t.col};
    case (t.func)
      FUNC_OPEN: begin
        if (open_depth >= STACK_DEPTH) begin
          kinds.push_back(KIND_FULL);
          refs.push_back(cur);
          full_rejects++;
        end else begin
          open_stack[open_depth] = cur;
          open_depth++;
          kinds.push_back(KIND_PUSHED);
          refs.push_back(cur);
        end
      end
      FUNC_CLOSE: begin
        if (open_depth == 0) begin
          kinds.push_back(KIND_CLOSE_EMPTY);
          refs.push_back(cur);
        end else begin
          top = open_stack[open_depth - 1];
          if (top.dtype == cur.dtype) begin
            if (cur.dtype == TYPE_BEGIN_END && !env_agrees(top, cur)) begin
              kinds.push_back(KIND_ENV_MISMATCH);
              refs.push_back(top);
            end else begin
              kinds.push_back(KIND_CLOSED);
              refs.push_back(top);
              open_depth--;
            end
          end else begin
            found = -1;
            if (cur.dtype <= T_BLOCK && struct_mask[cur.dtype]) begin
              for (i = open_depth - 1; i >= 0; i--) begin
                if (rec_matches(open_stack[i], cur)) begin
                  found = i;
                  break;
                end
              end
            end
            if (found >= 0) begin
              for (i = open_depth - 1; i > found; i--) begin
                kinds.push_back(KIND_UNCLOSED);
                refs.push_back(open_stack[i]);
                skipped_entries++;
              end
              kinds.push_back(KIND_CLOSED);
              refs.push_back(open_stack[found]);
              open_depth = found;
            end else begin
              kinds.push_back(KIND_MISMATCH);
              refs.push_back(top);
            end
          end
        end
      end
      FUNC_REPORT: begin
        if (open_depth == 0) begin
          kinds.push_back(KIND_NONE_OPEN);
          refs.push_back('{'0, 1'b0, '0, '0, '0});
        end else begin
          for (i = open_depth - 1; i >= 0; i--) begin
            kinds.push_back(KIND_UNCLOSED);
            refs.push_back(open_stack[i]);
          end
        end
      end
      default: ;
    endcase
    if (open_depth > peak_depth) peak_depth = open_depth;
    if (typed) begin
      pending_results.push_back(typed_res);
    end else begin
      for (i = 0; i < kinds.size(); i++) begin
        r.kind  = kinds[i];
        r.rec   = refs[i];
        r.depth = DEPTH_OUT_W'(open_depth);
        r.last  = (i == kinds.size() - 1);
        pending_results.push_back(r);
      end
    end
  endtask

  task automatic send_token(input token_t t, input bit typed, input result_t typed_res);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= t.func;
    in_delim_type <= t.dtype;
    in_has_env    <= t.has_env;
    in_env_id     <= t.env_id;
    in_src_line   <= t.line;
    in_src_col    <= t.col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tokens_accepted++;
    predict_matches(t, typed, typed_res);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(input logic [MASK_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    struct_mask = value;
  endtask

  function automatic logic [ENV_W-1:0] pick_env();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2, 3:    return '1;
      4:       return ENV_W'(1);
      5, 6:    return ENV_W'(2);
      default: return ENV_W'($urandom);
    endcase
  endfunction

  // Mostly opens and closes that pair up with the stack contents, plus
  // occasional bursts that fill the stack past its top.
  task automatic pick_token(output token_t t);
    int r;
    int idx;
    t.func    = FUNC_OPEN;
    t.dtype   = ($urandom_range(0, 99) < 85) ? TYPE_W'($urandom_range(0, T_BLOCK))
                                              : TYPE_W'($urandom_range(T_BLOCK + 1, T_UNKNOWN));
    t.has_env = 1'($urandom);
    t.env_id  = pick_env();
    t.line    = LINE_W'($urandom);
    t.col     = COL_W'($urandom);
    if (fill_left > 0) begin
      fill_left--;
      return;
    end
    if ($urandom_range(0, 99) < 2) fill_left = STACK_DEPTH + 2;
    r = $urandom_range(0, 99);
    if (r < 42) begin
      t.func = FUNC_OPEN;
    end else if (r < 82) begin
      t.func = FUNC_CLOSE;
      if (open_depth > 0) begin
        idx = (r < 70) ? open_depth - 1 : $urandom_range(0, open_depth - 1);
        t.dtype = open_stack[idx].dtype;
        if ($urandom_range(0, 99) < 85) begin
          t.has_env = open_stack[idx].has_env;
          t.env_id  = open_stack[idx].env_id;
        end
      end
    end else if (r < 90) begin
      t.func = FUNC_CLOSE;
    end else if (r < 96) begin
      t.func = FUNC_REPORT;
    end else begin
      t.func = FUNC_NOP;
    end
  endtask

  task automatic note_mismatch(input string what, input result_t want, input result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      $display("  want kind %0d type %0d env %0b/%h line %h col %h depth %0d last %0b",
               want.kind, want.rec.dtype, want.rec.has_env, want.rec.env_id,
               want.rec.line, want.rec.col, want.depth, want.last);
      $display("  got  kind %0d type %0d env %0b/%h line %h col %h depth %0d last %0b",
               got.kind, got.rec.dtype, got.rec.has_env, got.rec.env_id,
               got.rec.line, got.rec.col, got.depth, got.last);
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind  = out_result_kind;
      got.rec   = '{out_entry_type, out_entry_has_env, out_entry_env_id,
                    out_entry_line, out_entry_col};
      got.depth = out_depth_after;
      got.last  = out_last_result;
      results_checked++;
      if (pending_results.size() == 0) begin
        want = '{'0, '{'0, 1'b0, '0, '0, '0}, '0, 1'b0};
        note_mismatch("result with nothing pending", want, got);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.rec.dtype !== want.rec.dtype ||
            got.rec.has_env !== want.rec.has_env || got.rec.env_id !== want.rec.env_id ||
            got.rec.line !== want.rec.line || got.rec.col !== want.rec.col ||
            got.depth !== want.depth || got.last !== want.last) begin
          note_mismatch("field differs", want, got);
        end
      end
    end
  end

  initial begin : stimulus
    int idle_mix  [PHASES] = '{0, 61, 0, 13};
    int stall_mix [PHASES] = '{0, 0, 61, 13};
    token_t  tok;
    result_t typed_res;
    int      ph;
    int      row;
    int      counted;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row = 0; row < DIRECTED_ROWS; row++) begin
      tok = directed_rows[row].tok;
      typed_res.kind  = directed_rows[row].tkind;
      if (directed_rows[row].tkind == KIND_NONE_OPEN) begin
        typed_res.rec = '{'0, 1'b0, '0, '0, '0};
      end else begin
        typed_res.rec = '{tok.dtype, tok.has_env, tok.env_id, tok.line, tok.col};
      end
      typed_res.depth = DEPTH_OUT_W'(directed_rows[row].tdepth);
      typed_res.last  = 1'b1;
      send_token(tok, directed_rows[row].typed, typed_res);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        1:       write_mask('0);
        2:       write_mask('1);
        3:       write_mask(MASK_W'($urandom_range(0, 2047)));
        default: ;
      endcase
      idle_pct  = idle_mix[ph];
      stall_pct = stall_mix[ph];
      counted   = 0;
      while (counted < TOKENS_PER_PH) begin
        pick_token(tok);
        send_token(tok, 1'b0, typed_res);
        if (tok.func != FUNC_NOP) counted++;
      end
    end

    drain_results();
    $display("%0d tokens in, %0d results checked over %0d mask settings and idle/stall mixes",
             tokens_accepted, results_checked, PHASES);
    $display("peak depth %0d, %0d pushes onto a full stack, %0d entries skipped by searches",
             peak_depth, full_rejects, skipped_entries);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
